@@ design/cuc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_pkg: shared types and constants of the compressed integer codec
// Lead byte marks, operation and result codes, decoder result struct.
// ----------------------------------------------------------------------------
package cuc_pkg;

	localparam logic       OP_ENCODE  = 1'b0;
	localparam logic       OP_DECODE  = 1'b1;

	localparam logic       KIND_BYTE  = 1'b0;
	localparam logic       KIND_VALUE = 1'b1;

	localparam logic [7:0] LEAD_ONE   = 8'h80;
	localparam logic [7:0] LEAD_TWO   = 8'h40;
	localparam logic [7:0] LEAD_FOUR  = 8'h20;
	localparam logic [7:0] LEAD_FIVE  = 8'h10;
	localparam logic [7:0] LOW_NIBBLE = 8'h0F;

	localparam logic [31:0] LIMIT_ONE  = 32'h0000_0080;
	localparam logic [31:0] LIMIT_TWO  = 32'h0000_4000;
	localparam logic [31:0] LIMIT_FOUR = 32'h2000_0000;

	// decoder lead formats
	localparam logic [1:0] FMT_NONE = 2'd0;
	localparam logic [1:0] FMT_TWO  = 2'd1;
	localparam logic [1:0] FMT_FOUR = 2'd2;
	localparam logic [1:0] FMT_FIVE = 2'd3;

	typedef struct packed {
		logic        emit;
		logic [31:0] value;
		logic        format_error;
	} cuc_dec_res_t;

endpackage

@@ design/cuc_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_ifs: channel interfaces of the compressed integer codec
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface cuc_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] value;
	logic [7:0]  byte_in;

	modport source (output valid, op, value, byte_in, input ready);
	modport sink   (input valid, op, value, byte_in, output ready);
endinterface

interface cuc_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  byte_out;
	logic [31:0] value_out;
	logic        format_error;
	logic        last;

	modport source (output valid, kind, byte_out, value_out, format_error, last, input ready);
	modport sink   (input valid, kind, byte_out, value_out, format_error, last, output ready);
endinterface

interface cuc_cfg_if;
	logic valid;
	logic ready;
	logic tail_big_endian;

	modport source (output valid, tail_big_endian, input ready);
	modport sink   (input valid, tail_big_endian, output ready);
endinterface

@@ design/cuc_enc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_enc: encoder byte selector
// Builds the coded byte sequence of a value and picks the byte at an index.
// ----------------------------------------------------------------------------
module cuc_enc
	import cuc_pkg::*;
(
	input  logic [31:0] value,
	input  logic        tail_big_endian,
	input  logic [2:0]  idx,
	output logic [7:0]  byte_out,
	output logic        last
);

	logic [4:0][7:0] seq;
	logic [2:0]      count;

	always_comb begin
		seq = '0;
		if (value < LIMIT_ONE) begin
			count  = 3'd1;
			seq[0] = LEAD_ONE | value[7:0];
		end else if (value < LIMIT_TWO) begin
			count  = 3'd2;
			seq[0] = LEAD_TWO | {2'b00, value[13:8]};
			seq[1] = value[7:0];
		end else if (value < LIMIT_FOUR) begin
			count  = 3'd4;
			seq[0] = LEAD_FOUR | {3'b000, value[28:24]};
			seq[1] = value[23:16];
			seq[2] = tail_big_endian ? value[15:8] : value[7:0];
			seq[3] = tail_big_endian ? value[7:0]  : value[15:8];
		end else begin
			count  = 3'd5;
			seq[0] = LEAD_FIVE;
			seq[1] = tail_big_endian ? value[31:24] : value[7:0];
			seq[2] = tail_big_endian ? value[23:16] : value[15:8];
			seq[3] = tail_big_endian ? value[15:8]  : value[23:16];
			seq[4] = tail_big_endian ? value[7:0]   : value[31:24];
		end
	end

	always_comb begin
		case (idx)
			3'd0:    byte_out = seq[0];
			3'd1:    byte_out = seq[1];
			3'd2:    byte_out = seq[2];
			3'd3:    byte_out = seq[3];
			3'd4:    byte_out = seq[4];
			default: byte_out = '0;
		endcase
	end

	assign last = (idx == (count - 3'd1));

endmodule

@@ design/cuc_dec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_dec: decoder state and next-result logic
// Holds the running word and advances it by one coded byte per step.
// ----------------------------------------------------------------------------
module cuc_dec
	import cuc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   byte_in,
	input  logic         tail_big_endian,
	output cuc_dec_res_t res
);

	logic [2:0]  bytes_left_q,  bytes_left_d;
	logic [2:0]  tail_index_q,  tail_index_d;
	logic [1:0]  lead_format_q, lead_format_d;
	logic [31:0] acc_q,         acc_d;
	logic        pend_err_q,    pend_err_d;

	logic [2:0]  ti_clamp;
	logic [1:0]  pos;
	logic [1:0]  wmax;
	logic [31:0] acc_shift;

	always_comb begin
		bytes_left_d  = bytes_left_q;
		tail_index_d  = tail_index_q;
		lead_format_d = lead_format_q;
		acc_d         = acc_q;
		pend_err_d    = pend_err_q;
		res           = '0;
		wmax          = (lead_format_q == FMT_FOUR) ? 2'd1 : 2'd3;
		ti_clamp      = (tail_index_q > {1'b0, wmax}) ? {1'b0, wmax} : tail_index_q;
		pos           = tail_big_endian ? (wmax - ti_clamp[1:0]) : ti_clamp[1:0];
		acc_shift     = {24'b0, byte_in} << {pos, 3'b000};

		if (bytes_left_q == 3'd0) begin
			if (byte_in[7]) begin
				res = '{emit: 1'b1, value: {25'b0, byte_in[6:0]}, format_error: 1'b0};
			end else begin
				tail_index_d = 3'd0;
				pend_err_d   = 1'b0;
				if (byte_in[6]) begin
					acc_d         = {26'b0, byte_in[5:0]};
					lead_format_d = FMT_TWO;
					bytes_left_d  = 3'd1;
				end else if (byte_in[5]) begin
					acc_d         = {27'b0, byte_in[4:0]};
					lead_format_d = FMT_FOUR;
					bytes_left_d  = 3'd3;
				end else if (byte_in[4]) begin
					acc_d         = '0;
					lead_format_d = FMT_FIVE;
					bytes_left_d  = 3'd4;
					pend_err_d    = |(byte_in & LOW_NIBBLE);
				end else begin
					acc_d         = '0;
					lead_format_d = FMT_NONE;
					res = '{emit: 1'b1, value: 32'd0, format_error: 1'b1};
				end
			end
		end else begin
			if (lead_format_q == FMT_TWO ||
			    (lead_format_q == FMT_FOUR && bytes_left_q == 3'd3)) begin
				// plain byte right after the lead
				acc_d = (lead_format_q == FMT_FOUR) ? {acc_q[15:0], byte_in, 8'b0} << 8
				                                    : {acc_q[23:0], byte_in};
				tail_index_d = 3'd0;
			end else begin
				acc_d        = acc_q | acc_shift;
				tail_index_d = ti_clamp + 3'd1;
			end
			bytes_left_d = bytes_left_q - 3'd1;
			if (bytes_left_d == 3'd0) begin
				res = '{emit: 1'b1, value: acc_d, format_error: pend_err_q};
				pend_err_d    = 1'b0;
				tail_index_d  = 3'd0;
				lead_format_d = FMT_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			tail_index_q  <= '0;
			lead_format_q <= FMT_NONE;
			acc_q         <= '0;
			pend_err_q    <= 1'b0;
		end else if (step) begin
			bytes_left_q  <= bytes_left_d;
			tail_index_q  <= tail_index_d;
			lead_format_q <= lead_format_d;
			acc_q         <= acc_d;
			pend_err_q    <= pend_err_d;
		end
	end

endmodule

@@ design/compressed_uint_codec_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compressed_uint_codec_unit: prefix-coded 32-bit unsigned integer codec
// Encodes values into 1, 2, 4 or 5 bytes and decodes a byte stream to values.
// ----------------------------------------------------------------------------
// Usage:
//   request: one request per valid/ready handshake. op 0 encodes value,
//     op 1 feeds one coded byte_in to the decoder.
//   result: coded bytes (kind 0, last on the final byte) or decoded values
//     (kind 1, format_error on a bad lead byte).
//   cfg: one write sets tail_big_endian; it is always ready. Write it only
//     while no request is in flight.
//   Path: a request is taken into the input register, and its first
//     result then passes to the result register.
//   Throughput: a decode byte or one-byte encode every cycle while result
//     does not stall; an encode holds the input register until all its
//     bytes (up to 5) are out; the result register takes one byte per cycle.
//   A decode byte that does not complete a word leaves without a result.
//   Reset clears the pipeline, the decoder state and tail_big_endian.
//   When result stalls, the result register holds and request.ready drops
//   once the input register also holds a request that needs a result.
// ----------------------------------------------------------------------------
module compressed_uint_codec_unit
	import cuc_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	cuc_req_if.sink   request,
	cuc_rsp_if.source result,
	cuc_cfg_if.sink   cfg
);

	logic         tbe_q;

	logic         s1_valid_q;
	logic         op_s1;
	logic [31:0]  value_s1;
	logic [7:0]   byte_s1;
	logic [2:0]   idx_q;

	logic         s2_valid_q;
	logic         kind_s2;
	logic [7:0]   byte_s2;
	logic [31:0]  value_s2;
	logic         err_s2;
	logic         last_s2;

	logic [7:0]   enc_byte;
	logic         enc_last;
	cuc_dec_res_t dec_res;

	logic         s2_free;
	logic         s1_emit;
	logic         s1_put;
	logic         s1_done;
	logic         dec_step;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbe_q <= 1'b0;
		end else if (cfg.valid) begin
			tbe_q <= cfg.tail_big_endian;
		end
	end

	cuc_enc u_enc (
		.value           (value_s1),
		.tail_big_endian (tbe_q),
		.idx             (idx_q),
		.byte_out        (enc_byte),
		.last            (enc_last)
	);

	cuc_dec u_dec (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (dec_step),
		.byte_in         (byte_s1),
		.tail_big_endian (tbe_q),
		.res             (dec_res)
	);

	assign s2_free  = !s2_valid_q || result.ready;
	assign s1_emit  = (op_s1 == OP_ENCODE) || dec_res.emit;
	assign s1_put   = s1_valid_q && s1_emit && s2_free;
	assign s1_done  = s1_valid_q && ((op_s1 == OP_ENCODE) ? (s2_free && enc_last)
	                                                      : (!dec_res.emit || s2_free));
	assign dec_step = s1_done && (op_s1 == OP_DECODE);

	assign request.ready = !s1_valid_q || s1_done;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (request.ready) begin
				s1_valid_q <= request.valid;
			end
			if (s1_done) begin
				idx_q <= '0;
			end else if (s1_put) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			op_s1    <= request.op;
			value_s1 <= request.value;
			byte_s1  <= request.byte_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_put) begin
			s2_valid_q <= 1'b1;
		end else if (result.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_put) begin
			if (op_s1 == OP_ENCODE) begin
				kind_s2  <= KIND_BYTE;
				byte_s2  <= enc_byte;
				value_s2 <= '0;
				err_s2   <= 1'b0;
				last_s2  <= enc_last;
			end else begin
				kind_s2  <= KIND_VALUE;
				byte_s2  <= '0;
				value_s2 <= dec_res.value;
				err_s2   <= dec_res.format_error;
				last_s2  <= 1'b1;
			end
		end
	end

	assign result.valid        = s2_valid_q;
	assign result.kind         = kind_s2;
	assign result.byte_out     = byte_s2;
	assign result.value_out    = value_s2;
	assign result.format_error = err_s2;
	assign result.last         = last_s2;

endmodule

@@ tb/compressed_uint_codec_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compressed_uint_codec_unit_tb: self-checking bench for the integer codec
// Drives encode and decode requests in random bursts, stalls the result side,
// predicts every coded byte and decoded value, and compares them in order.
// ----------------------------------------------------------------------------
module compressed_uint_codec_unit_tb;
	import cuc_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned LONG_HOLD    = 200;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic        kind;
		logic [7:0]  byte_out;
		logic [31:0] value_out;
		logic        format_error;
		logic        last;
	} codec_result_t;

	typedef enum int unsigned {SINK_OPEN, SINK_COIN, SINK_THIRD, SINK_MOSTLY} sink_mode_t;
	typedef enum int unsigned {FORM_ONE, FORM_TWO, FORM_FOUR, FORM_FIVE, FORM_BAD} word_form_t;

	class codec_scoreboard;
		logic          big_endian;
		logic [2:0]    bytes_left;
		logic [2:0]    tail_index;
		logic [1:0]    lead_fmt;
		logic [31:0]   acc;
		logic          pend_err;
		codec_result_t expected_q[$];
		int unsigned   mismatches;

		function new();
			big_endian = 1'b0;
			bytes_left = '0;
			tail_index = '0;
			lead_fmt   = FMT_NONE;
			acc        = '0;
			pend_err   = 1'b0;
			mismatches = 0;
		endfunction

		function void set_order(logic be);
			big_endian = be;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void push(logic kind, logic [7:0] b, logic [31:0] v, logic err, logic last);
			codec_result_t r;
			r.kind         = kind;
			r.byte_out     = b;
			r.value_out    = v;
			r.format_error = err;
			r.last         = last;
			expected_q = {expected_q, r};
		endfunction

		// emit a tail word low or high byte first, per the current order
		function void push_tail(logic [31:0] v, int unsigned n);
			int unsigned sh;
			for (int unsigned i = 0; i < n; i++) begin
				sh = big_endian ? 8 * (n - 1 - i) : 8 * i;
				push(KIND_BYTE, 8'(v >> sh), '0, 1'b0, i == n - 1);
			end
		endfunction

		function void note_request(logic op, logic [31:0] v, logic [7:0] b);
			int unsigned width;
			int unsigned sh;
			if (op == OP_ENCODE) begin
				if (v < LIMIT_ONE) begin
					push(KIND_BYTE, LEAD_ONE | v[7:0], '0, 1'b0, 1'b1);
				end else if (v < LIMIT_TWO) begin
					push(KIND_BYTE, LEAD_TWO | v[15:8], '0, 1'b0, 1'b0);
					push(KIND_BYTE, v[7:0], '0, 1'b0, 1'b1);
				end else if (v < LIMIT_FOUR) begin
					push(KIND_BYTE, LEAD_FOUR | v[31:24], '0, 1'b0, 1'b0);
					push(KIND_BYTE, v[23:16], '0, 1'b0, 1'b0);
					push_tail({16'd0, v[15:0]}, 2);
				end else begin
					push(KIND_BYTE, LEAD_FIVE, '0, 1'b0, 1'b0);
					push_tail(v, 4);
				end
			end else if (bytes_left == 0) begin
				if ((b & LEAD_ONE) != 0) begin
					push(KIND_VALUE, '0, {25'd0, b[6:0]}, 1'b0, 1'b1);
				end else begin
					tail_index = '0;
					pend_err   = 1'b0;
					if ((b & LEAD_TWO) != 0) begin
						acc        = {26'd0, b[5:0]};
						lead_fmt   = FMT_TWO;
						bytes_left = 3'd1;
					end else if ((b & LEAD_FOUR) != 0) begin
						acc        = {27'd0, b[4:0]};
						lead_fmt   = FMT_FOUR;
						bytes_left = 3'd3;
					end else if ((b & LEAD_FIVE) != 0) begin
						acc        = '0;
						lead_fmt   = FMT_FIVE;
						bytes_left = 3'd4;
						pend_err   = (b & LOW_NIBBLE) != 0;
					end else begin
						// no length bit: flag at once, stay awaiting a lead
						acc      = '0;
						lead_fmt = FMT_NONE;
						push(KIND_VALUE, '0, '0, 1'b1, 1'b1);
					end
				end
			end else begin
				if (lead_fmt == FMT_TWO || (lead_fmt == FMT_FOUR && bytes_left == 3)) begin
					acc = (acc << 8) | {24'd0, b};
					if (lead_fmt == FMT_FOUR)
						acc = acc << 16;
					tail_index = '0;
				end else begin
					width = (lead_fmt == FMT_FOUR) ? 2 : 4;
					if (tail_index >= width)
						tail_index = 3'(width - 1);
					sh = big_endian ? 8 * (width - 1 - tail_index) : 8 * tail_index;
					acc = acc | ({24'd0, b} << sh);
					tail_index = tail_index + 3'd1;
				end
				bytes_left = bytes_left - 3'd1;
				if (bytes_left == 0) begin
					push(KIND_VALUE, '0, acc, pend_err, 1'b1);
					pend_err   = 1'b0;
					tail_index = '0;
					lead_fmt   = FMT_NONE;
				end
			end
		endfunction

		function void check_result(logic kind, logic [7:0] b, logic [31:0] v, logic err,
				logic last);
			codec_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"%0t: result with nothing pending: ",
						"kind %0d byte %02h value %08h err %0d last %0d"},
						$realtime, kind, b, v, err, last);
				return;
			end
			want = expected_q.pop_front();
			if (kind !== want.kind || b !== want.byte_out || v !== want.value_out ||
					err !== want.format_error || last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"%0t: result mismatch: ",
						"expected kind %0d byte %02h value %08h err %0d last %0d, ",
						"got kind %0d byte %02h value %08h err %0d last %0d"},
						$realtime, want.kind, want.byte_out, want.value_out,
						want.format_error, want.last, kind, b, v, err, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cuc_req_if req_ch();
	cuc_rsp_if rsp_ch();
	cuc_cfg_if cfg_ch();

	codec_scoreboard sb = new();

	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned idle_cycles;
	bit          hold_results;

	compressed_uint_codec_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// note configuration, requests and results in one place, in a fixed order
	always @(posedge clk) begin
		if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
			sb.set_order(cfg_ch.tail_big_endian);
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
			sb.note_request(req_ch.op, req_ch.value, req_ch.byte_in);
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_result(rsp_ch.kind, rsp_ch.byte_out, rsp_ch.value_out,
				rsp_ch.format_error, rsp_ch.last);
		if (arst_n !== 1'b1 || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) ||
				(req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : result_sink
		int unsigned cyc;
		sink_mode_t  mode;
		cyc  = 0;
		mode = SINK_OPEN;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 40 == 0)
				mode = sink_mode_t'($urandom_range(0, 3));
			if (hold_results) begin
				// hold off long enough for the block to back up into the request side
				hold_results = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				case (mode)
					SINK_OPEN:   rsp_ch.ready <= 1'b1;
					SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					SINK_THIRD:  rsp_ch.ready <= (cyc % 3 == 0);
					default:     rsp_ch.ready <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	task automatic send_request(input logic op, input logic [31:0] v, input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.value   <= v;
		req_ch.byte_in <= b;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_encode(input logic [31:0] v);
		send_request(OP_ENCODE, v, 8'($urandom));
	endtask

	task automatic send_decode(input logic [7:0] b);
		send_request(OP_DECODE, $urandom, b);
	endtask

	// drop valid and wait until every pending result is out, plus the pipeline depth
	task automatic settle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_order(input logic be);
		settle();
		cfg_ch.valid           <= 1'b1;
		cfg_ch.tail_big_endian <= be;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, LIMIT_ONE - 1);
			1:       return $urandom_range(LIMIT_ONE, LIMIT_TWO - 1);
			2:       return $urandom_range(LIMIT_TWO, LIMIT_FOUR - 1);
			default: return $urandom_range(LIMIT_FOUR, 32'hFFFF_FFFF);
		endcase
	endfunction

	// random coded word, at times with a bad lead, now and then split by an encode
	task automatic send_word();
		word_form_t  form;
		int unsigned tail_len;
		logic [7:0]  r;
		logic [7:0]  lead;
		form = word_form_t'($urandom_range(0, 4));
		r    = 8'($urandom);
		case (form)
			FORM_ONE: begin
				lead     = LEAD_ONE | {1'b0, r[6:0]};
				tail_len = 0;
			end
			FORM_TWO: begin
				lead     = LEAD_TWO | {2'b00, r[5:0]};
				tail_len = 1;
			end
			FORM_FOUR: begin
				lead     = LEAD_FOUR | {3'b000, r[4:0]};
				tail_len = 3;
			end
			FORM_FIVE: begin
				lead     = ($urandom_range(0, 3) == 0) ? (LEAD_FIVE | (r & LOW_NIBBLE))
				                                       : LEAD_FIVE;
				tail_len = 4;
			end
			default: begin
				lead     = r & LOW_NIBBLE;
				tail_len = 0;
			end
		endcase
		send_decode(lead);
		repeat (tail_len) begin
			if ($urandom_range(0, 7) == 0)
				send_encode(pick_value());
			send_decode(8'($urandom));
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 19);
			if (pick < 6)
				send_encode(pick_value());
			else if (pick < 17)
				send_word();
			else
				send_decode(8'($urandom));
		end
	endtask

	initial begin
		items_sent   = 0;
		burst_left   = 0;
		idle_cycles  = 0;
		hold_results = 1'b0;
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.op              <= OP_ENCODE;
		req_ch.value           <= '0;
		req_ch.byte_in         <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.tail_big_endian <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// range edges of every encoded length
		send_encode(32'h0000_0000);
		send_encode(32'h0000_007F);
		send_encode(32'h0000_0080);
		send_encode(32'h0000_3FFF);
		send_encode(32'h0000_4000);
		send_encode(32'h1FFF_FFFF);
		send_encode(32'h2000_0000);
		send_encode(32'hFFFF_FFFF);

		// single byte, lead without length bit, two- and four-byte words
		send_decode(8'hFF);
		send_decode(8'h00);
		send_decode(8'h0F);
		send_decode(8'h7F);
		send_decode(8'hFF);
		send_decode(8'h3F);
		send_decode(8'h12);
		send_decode(8'h34);
		send_decode(8'h56);

		// bad five-byte lead, with an encode slipped into the word
		send_decode(8'h1F);
		send_encode(32'h0000_3FFF);
		send_decode(8'hAA);
		send_decode(8'hBB);
		send_decode(8'hCC);
		send_decode(8'hDD);

		// flip the tail order halfway through a five-byte word
		send_decode(LEAD_FIVE);
		send_decode(8'h11);
		send_decode(8'h22);
		write_order(1'b1);
		send_decode(8'h33);
		send_decode(8'h44);

		write_order(1'b0);
		hold_results = 1'b1;
		run_random(36);
		write_order(1'b1);
		run_random(36);
		write_order(1'($urandom_range(0, 1)));
		run_random(36);
		write_order(1'b0);
		run_random(36);

		settle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
